/* rtl/b32ca_pkg.sv */
// Types, constants and character table for the base32 custom alphabet encoder.
package b32ca_pkg;

    localparam int unsigned GROUP_BITS = 5;
    localparam int unsigned MAX_CHARS  = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] code_char;
        logic       final_char;
    } t_out;

    function automatic logic [7:0] f_alphabet(input logic [GROUP_BITS-1:0] g);
        logic [7:0] c;
        case (g)
            5'd0:    c = "a";
            5'd1:    c = "b";
            5'd2:    c = "c";
            5'd3:    c = "d";
            5'd4:    c = "W";
            5'd5:    c = "X";
            5'd6:    c = "Y";
            5'd7:    c = "Z";
            5'd8:    c = "0";
            5'd9:    c = "1";
            5'd10:   c = "2";
            5'd11:   c = "3";
            5'd12:   c = "E";
            5'd13:   c = "F";
            5'd14:   c = "G";
            5'd15:   c = "H";
            5'd16:   c = "A";
            5'd17:   c = "B";
            5'd18:   c = "C";
            5'd19:   c = "D";
            5'd20:   c = "4";
            5'd21:   c = "5";
            5'd22:   c = "6";
            5'd23:   c = "7";
            5'd24:   c = "8";
            5'd25:   c = "9";
            5'd26:   c = "w";
            5'd27:   c = "x";
            5'd28:   c = "y";
            5'd29:   c = "z";
            5'd30:   c = "j";
            default: c = "k";
        endcase
        return c;
    endfunction

endpackage

/* rtl/base32_custom_alphabet_encoder.sv */
// Streaming unpadded base32 encoder with a fixed custom alphabet, top level.
//
// Each accepted byte is split into 5-bit groups and its one to three
// characters are parked in a small character buffer; the buffer drains one
// character per cycle into the output register while the output is not
// stalled. The output side therefore sets the pace: a byte takes one output
// slot per character it produces, which averages 1.6 characters per byte
// over a long message. A new byte is taken in the same cycle the buffer
// hands over its last character, so the input never waits on an idle cycle.
// The final character of a message carries final_char; the bit accumulator
// clears when the last byte of the message is taken.
module base32_custom_alphabet_encoder
    import b32ca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic [3:0]  r_lo_bits;
    logic [2:0]  r_lo_cnt;
    logic [7:0]  r_buf [MAX_CHARS];
    logic [1:0]  r_left;
    logic [1:0]  r_idx;
    logic        r_final;
    logic        r_out_valid;
    t_out        r_out;

    logic        moving;
    logic        accept;
    logic [3:0]  total;
    logic [3:0]  sh;
    logic [14:0] w;
    logic        two_full;
    logic [3:0]  rem;
    logic        pad;
    logic [1:0]  n_chars;

    assign moving     = (r_left != 2'd0) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_left == 2'd0) || ((r_left == 2'd1) && moving));
    assign accept     = i_in_valid && !o_in_stall;

    assign total    = 4'(r_lo_cnt) + 4'd8;
    assign sh       = 4'd15 - total;
    assign w        = {3'b000, r_lo_bits, i_in_data.data_byte} << sh;
    assign two_full = total >= 4'd10;
    assign rem      = two_full ? (total - 4'd10) : (total - 4'd5);
    assign pad      = i_in_data.end_of_message && (rem != 4'd0);
    assign n_chars  = (two_full ? 2'd2 : 2'd1) + {1'b0, pad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_bits <= '0;
            r_lo_cnt  <= '0;
            r_left    <= '0;
            r_idx     <= '0;
            r_final   <= 1'b0;
        end else if (accept) begin
            r_left  <= n_chars;
            r_idx   <= '0;
            r_final <= i_in_data.end_of_message;
            if (i_in_data.end_of_message) begin
                r_lo_bits <= '0;
                r_lo_cnt  <= '0;
            end else begin
                r_lo_bits <= i_in_data.data_byte[3:0];
                r_lo_cnt  <= rem[2:0];
            end
        end else if (moving) begin
            r_left <= r_left - 2'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[0] <= f_alphabet(w[14:10]);
            r_buf[1] <= f_alphabet(w[9:5]);
            r_buf[2] <= f_alphabet(w[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (moving) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (moving) begin
            r_out.code_char  <= r_buf[r_idx];
            r_out.final_char <= r_final && (r_left == 2'd1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_lo_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_cnt <= 3'd4)
        else $error("leftover count above four");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_left != 2'd0) && (r_idx == 2'd0))
        else $error("transfer did not load the character buffer");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 2'd0) |-> ((2'(r_idx + r_left)) <= 2'd3) && (r_idx != 2'd3))
        else $error("buffer index out of range");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.end_of_message) |=> (r_lo_cnt == 3'd0))
        else $error("accumulator not cleared at end of message");

endmodule

/* test/tb.sv */
// Self-checking testbench for the streaming base32 custom alphabet encoder.
module tb
    import b32ca_pkg::*;
;

    localparam int PHASE1_AT   = 110;
    localparam int PHASE2_AT   = 220;
    localparam int DRAIN_AT    = 160;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 60;
    localparam int MIN_ITEMS   = 320;
    localparam logic [8*32-1:0] CHAR_TABLE = "abcdWXYZ0123EFGHABCD456789wxyzjk";

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    t_in  byte_queue[$];
    t_out pending_chars[$];
    logic [3:0] bit_store;
    int   bit_count;
    int   total_items;
    int   n_sent;
    int   fault_count;
    bit   draining;
    bit   hold_done;
    int   hold_left;

    base32_custom_alphabet_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic push_byte(input logic [7:0] b, input logic eom);
        t_in item;
        item.data_byte      = b;
        item.end_of_message = eom;
        byte_queue.push_back(item);
    endtask

    task automatic encode_byte(input t_in item);
        logic [11:0] word;
        logic [4:0]  grp;
        int          bits_left;
        int          n;
        t_out        chars[3];
        word      = {bit_store, item.data_byte};
        bits_left = bit_count + 8;
        n         = 0;
        while (bits_left >= 5) begin
            grp = 5'((word >> (bits_left - 5)) & 12'h1f);
            chars[n].code_char  = CHAR_TABLE[8*(31-grp) +: 8];
            chars[n].final_char = 1'b0;
            n++;
            bits_left -= 5;
        end
        word = word & ((12'd1 << bits_left) - 12'd1);
        if (item.end_of_message) begin
            if (bits_left > 0) begin
                grp = 5'((word << (5 - bits_left)) & 12'h1f);
                chars[n].code_char  = CHAR_TABLE[8*(31-grp) +: 8];
                chars[n].final_char = 1'b0;
                n++;
            end
            chars[n-1].final_char = 1'b1;
            bit_store = '0;
            bit_count = 0;
        end else begin
            bit_store = word[3:0];
            bit_count = bits_left;
        end
        for (int k = 0; k < n; k++)
            pending_chars.push_back(chars[k]);
    endtask

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : driver
        logic next_valid;
        t_in  next_data;
        int   sent_now;
        int   idle_pct;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            next_data  = in_data;
            sent_now   = n_sent;
            if (in_valid && !in_stall) begin
                encode_byte(in_data);
                sent_now   = n_sent + 1;
                next_valid = 1'b0;
                if (sent_now == DRAIN_AT)
                    draining = 1'b1;
            end
            if (draining && pending_chars.size() == 0)
                draining = 1'b0;
            idle_pct = sent_now < PHASE1_AT ? 19 : (sent_now < PHASE2_AT ? 59 : 0);
            if (!next_valid && !draining && byte_queue.size() != 0
                    && $urandom_range(0, 99) >= idle_pct) begin
                next_valid = 1'b1;
                next_data  = byte_queue.pop_front();
            end
            in_valid <= next_valid;
            in_data  <= next_data;
            n_sent   <= sent_now;
        end
    end

    always @(posedge i_clk) begin : receiver
        int stall_pct;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            stall_pct = n_sent < PHASE1_AT ? 59 : (n_sent < PHASE2_AT ? 19 : 0);
            out_stall <= $urandom_range(0, 99) < stall_pct;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_chars.size() == 0) begin
                log_fault($sformatf("unexpected transfer: char %h final %b",
                                    out_data.code_char, out_data.final_char));
            end else begin
                want = pending_chars.pop_front();
                if (out_data.code_char !== want.code_char
                        || out_data.final_char !== want.final_char)
                    log_fault($sformatf("mismatch: expected char %h final %b, got char %h final %b",
                                        want.code_char, want.final_char,
                                        out_data.code_char, out_data.final_char));
            end
        end
    end

    initial begin
        #400000;
        $display("base32_custom_alphabet_encoder test failed");
        $finish;
    end

    initial begin
        int len;
        int coin;
        logic [7:0] b;
        bit_store   = '0;
        bit_count   = 0;
        n_sent      = 0;
        fault_count = 0;
        draining    = 1'b0;
        hold_done   = 1'b0;
        hold_left   = 0;

        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        for (int k = 0; k < 5; k++)
            push_byte(8'hff, k == 4);
        for (int k = 0; k < 5; k++)
            push_byte(8'h00, k == 4);
        push_byte(8'ha5, 1'b0);
        push_byte(8'h5a, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7f, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'hc6, 1'b0);
        push_byte(8'hf8, 1'b1);

        while (byte_queue.size() < MIN_ITEMS) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                coin = $urandom_range(0, 7);
                if (coin == 0)
                    b = 8'h00;
                else if (coin == 1)
                    b = 8'hff;
                else
                    b = 8'($urandom_range(0, 255));
                push_byte(b, k == len - 1);
            end
        end
        total_items = byte_queue.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != total_items)
            @(posedge i_clk);
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fault_count == 0)
            $display("base32_custom_alphabet_encoder test passed");
        else
            $display("base32_custom_alphabet_encoder test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/b32ca_pkg.sv
rtl/base32_custom_alphabet_encoder.sv
test/tb.sv
